### rtl/core/gdn_pkg.sv
// shared types, constants and the month offset table of the day-number unit
// no dependencies; imported by every module of the block
package gdn_pkg;

    localparam int YEAR_MAX   = 9999;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int NUM_W      = 24;

    localparam int SER_BIAS_Y = 4800;
    localparam int SER_ANCHOR = 32045;
    localparam int INV_ANCHOR = 32044;
    localparam int DAYS_400Y  = 146097;
    localparam int DAYS_4Y    = 1461;
    localparam int MONTH_SPAN = 153;
    localparam int DAYS_YEAR  = 365;
    localparam int YEARS_CENT = 100;

    // floor(y / 100) as (y * 5243) >> 19, exact for y below 43690
    localparam int RECIP_100    = 5243;
    localparam int RECIP_100_SH = 19;

    // biased year of any 14-bit field pattern, and its serial
    localparam int SY_W  = YEAR_W + 1;
    localparam int SER_W = 23;
    // serial plus signed offset
    localparam int SUM_W = NUM_W + 1;

    // supported serial range: 0-01-01 up to YEAR_MAX-12-31
    localparam int LO_Y   = SER_BIAS_Y - 1;
    localparam int SER_LO = 1 + (MONTH_SPAN * 10 + 2) / 5 + DAYS_YEAR * LO_Y + LO_Y / 4
                          - LO_Y / 100 + LO_Y / 400 - SER_ANCHOR;
    localparam int HI_Y   = YEAR_MAX + SER_BIAS_Y;
    localparam int SER_HI = 31 + (MONTH_SPAN * 9 + 2) / 5 + DAYS_YEAR * HI_Y + HI_Y / 4
                          - HI_Y / 100 + HI_Y / 400 - SER_ANCHOR;

    // serial to date widths
    localparam int A_MAX = SER_HI + INV_ANCHOR;
    localparam int A_W   = $clog2(A_MAX + 1);
    localparam int NB_W  = A_W + 2;
    localparam int KB    = (2 ** NB_W) / DAYS_400Y;
    localparam int KB_W  = $clog2(KB + 1);
    localparam int PB_W  = NB_W + KB_W;
    localparam int B_MAX = (4 * A_MAX + 3) / DAYS_400Y;
    localparam int B_W   = $clog2(B_MAX + 1);
    localparam int C_W   = $clog2(DAYS_400Y / 4 + 1);
    localparam int NY_W  = C_W + 2;
    localparam int KY    = (2 ** NY_W) / DAYS_4Y;
    localparam int KY_W  = $clog2(KY + 1);
    localparam int PY_W  = NY_W + KY_W;
    localparam int Y4_W  = $clog2((4 * (DAYS_400Y / 4) + 3) / DAYS_4Y + 1);
    localparam int E_W   = $clog2(DAYS_4Y / 4 + 1);
    localparam int YB_W  = $clog2(YEARS_CENT * B_MAX + YEARS_CENT + 2);
    localparam int YS_W  = (YB_W > YEAR_W) ? YB_W : YEAR_W;

    localparam int SER_STAGES  = 3;
    localparam int DATE_STAGES = 9;
    localparam int LATENCY     = SER_STAGES + 1 + DATE_STAGES;

    typedef enum logic [1:0] {
        ACT_DATE_TO_SERIAL = 2'd0,
        ACT_SERIAL_TO_DATE = 2'd1,
        ACT_DAYS_BETWEEN   = 2'd2,
        ACT_ADD_DAYS       = 2'd3
    } action_t;

    typedef struct packed {
        action_t                   action;
        logic [YEAR_W-1:0]         first_year;
        logic [MONTH_W-1:0]        first_month;
        logic [DAY_W-1:0]          first_day;
        logic [YEAR_W-1:0]         second_year;
        logic [MONTH_W-1:0]        second_month;
        logic [DAY_W-1:0]          second_day;
        logic signed [NUM_W-1:0]   amount;
    } gdn_req_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]   number;
        logic [YEAR_W-1:0]         out_year;
        logic [MONTH_W-1:0]        out_month;
        logic [DAY_W-1:0]          out_day;
        logic                      range_error;
    } gdn_res_t;

    // side information riding along with the serial into the date converter
    typedef struct packed {
        logic                      conv;
        logic [NUM_W-1:0]          number;
    } gdn_tag_t;

    // first day of a march-based month, (153 * k + 2) / 5
    function automatic logic [8:0] month_ofs(input logic [3:0] k);
        logic [8:0] ofs;
        case (k)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            4'd12:   ofs = 9'd367;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

### rtl/core/gdn_serial.sv
// date to serial day number, three register stages
// depends on gdn_pkg
module gdn_serial
    import gdn_pkg::*;
(
    input  logic               clk,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    output logic [SER_W-1:0]   serial
);

    localparam int P_W = SY_W + 13;

    logic               jf;
    logic [MONTH_W-1:0] mi;
    logic [SY_W-1:0]    y1_next;
    logic [9:0]         ds1_next;
    logic [SY_W-1:0]    y1_reg;
    logic [9:0]         ds1_reg;

    logic [P_W-1:0]     p100;
    logic [P_W-1:0]     p400;
    logic [SER_W-1:0]   y365_next;
    logic [SY_W-1:0]    q4_next;
    logic [SY_W-1:0]    q100_next;
    logic [SY_W-1:0]    q400_next;
    logic [SER_W-1:0]   y365_reg;
    logic [SY_W-1:0]    q4_reg;
    logic [SY_W-1:0]    q100_reg;
    logic [SY_W-1:0]    q400_reg;
    logic [9:0]         ds2_reg;

    logic [SER_W-1:0]   serial_next;
    logic [SER_W-1:0]   serial_reg;

    // january and february belong to the previous march-based year
    always_comb
    begin
        jf       = (month <= MONTH_W'(2));
        mi       = jf ? month + MONTH_W'(9) : month - MONTH_W'(3);
        y1_next  = SY_W'(year) + SY_W'(SER_BIAS_Y) - SY_W'(jf);
        ds1_next = 10'(day) + 10'(month_ofs(mi));
    end

    always_comb
    begin
        y365_next = SER_W'(y1_reg) * SER_W'(DAYS_YEAR);
        p100      = P_W'(y1_reg) * P_W'(RECIP_100);
        p400      = P_W'(y1_reg[SY_W-1:2]) * P_W'(RECIP_100);
        q4_next   = y1_reg >> 2;
        q100_next = SY_W'(p100 >> RECIP_100_SH);
        q400_next = SY_W'(p400 >> RECIP_100_SH);
    end

    // true value is never negative and fits the serial width
    always_comb
    begin
        serial_next = y365_reg + SER_W'(q4_reg) - SER_W'(q100_reg) + SER_W'(q400_reg)
                    + SER_W'(ds2_reg) - SER_W'(SER_ANCHOR);
    end

    always_ff @(posedge clk)
    begin
        y1_reg     <= y1_next;
        ds1_reg    <= ds1_next;
        y365_reg   <= y365_next;
        q4_reg     <= q4_next;
        q100_reg   <= q100_next;
        q400_reg   <= q400_next;
        ds2_reg    <= ds1_reg;
        serial_reg <= serial_next;
    end

    assign serial = serial_reg;

endmodule

### rtl/core/gdn_date.sv
// serial day number to date with range check, nine register stages
// depends on gdn_pkg
module gdn_date
    import gdn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [SUM_W-1:0] serial,
    input  gdn_tag_t                tag,
    output logic                    out_valid,
    output gdn_res_t                result
);

    typedef struct packed {
        logic             blank;
        logic             err;
        logic [NUM_W-1:0] number;
    } side_t;

    localparam int SIDE_N = DATE_STAGES - 1;

    logic [DATE_STAGES-1:0] vld_reg;
    side_t                  side_next;
    side_t                  side_reg [SIDE_N];

    logic [A_W-1:0]   a1_next;
    logic [A_W-1:0]   a1_reg, a2_reg, a3_reg;
    logic [PB_W-1:0]  pb2_next, pb2_reg;

    logic [KB_W-1:0]  qb;
    logic [NB_W:0]    qbd;
    logic [NB_W:0]    rb;
    logic [B_W-1:0]   b3_next;
    logic [B_W-1:0]   b3_reg, b4_reg, b5_reg, b6_reg;

    logic [A_W+1:0]   pc;
    logic [C_W-1:0]   c4_next;
    logic [C_W-1:0]   c4_reg, c5_reg, c6_reg;
    logic [PY_W-1:0]  py5_next, py5_reg;

    logic [KY_W-1:0]  qy;
    logic [NY_W:0]    qyd;
    logic [NY_W:0]    ry;
    logic [Y4_W-1:0]  y6_next, y6_reg;

    logic [C_W+1:0]   pe;
    logic [E_W-1:0]   e7_next, e7_reg, e8_reg;
    logic [YB_W-1:0]  yb7_next, yb7_reg, yb8_reg;

    logic [3:0]       m8_next, m8_reg;

    logic             wrap;
    gdn_res_t         res_next, res_reg;

    // stage 1: range check and offset into the 400-year cycle
    always_comb
    begin
        side_next.err    = tag.conv && ((serial < SER_LO) || (serial > SER_HI));
        side_next.blank  = !tag.conv || side_next.err;
        side_next.number = tag.number;
        a1_next          = A_W'(serial) + A_W'(INV_ANCHOR);
    end

    // stage 2: reciprocal estimate of the 400-year quotient
    assign pb2_next = PB_W'({a1_reg, 2'b11}) * PB_W'(KB);

    // stage 3: the estimate is at most one low
    always_comb
    begin
        qb      = pb2_reg[PB_W-1:NB_W];
        qbd     = (NB_W+1)'(qb) * (NB_W+1)'(DAYS_400Y);
        rb      = (NB_W+1)'({a2_reg, 2'b11}) - qbd;
        b3_next = B_W'({1'b0, qb} + (KB_W+1)'(rb >= (NB_W+1)'(DAYS_400Y)));
    end

    // stage 4: day within the 400-year cycle
    always_comb
    begin
        pc      = (A_W+2)'(b3_reg) * (A_W+2)'(DAYS_400Y);
        c4_next = C_W'(a3_reg - pc[A_W+1:2]);
    end

    // stage 5: reciprocal estimate of the 4-year quotient
    assign py5_next = PY_W'({c4_reg, 2'b11}) * PY_W'(KY);

    // stage 6: correct it
    always_comb
    begin
        qy      = py5_reg[PY_W-1:NY_W];
        qyd     = (NY_W+1)'(qy) * (NY_W+1)'(DAYS_4Y);
        ry      = (NY_W+1)'({c5_reg, 2'b11}) - qyd;
        y6_next = Y4_W'({1'b0, qy} + (KY_W+1)'(ry >= (NY_W+1)'(DAYS_4Y)));
    end

    // stage 7: day within the march-based year, biased year
    always_comb
    begin
        pe       = (C_W+2)'(y6_reg) * (C_W+2)'(DAYS_4Y);
        e7_next  = E_W'(c6_reg - pe[C_W+1:2]);
        yb7_next = YB_W'(b6_reg) * YB_W'(YEARS_CENT) + YB_W'(y6_reg);
    end

    // stage 8: month from the month start thresholds, which rise with k
    always_comb
    begin
        m8_next = '0;
        for (int k = 1; k < 12; k++)
        begin
            if (e7_reg >= E_W'(month_ofs(4'(k))))
                m8_next = 4'(k);
        end
    end

    // stage 9: calendar fields; march-based months 10 and 11 are jan and feb
    always_comb
    begin
        wrap                 = (m8_reg >= 4'd10);
        res_next.number      = side_reg[SIDE_N-1].number;
        res_next.range_error = side_reg[SIDE_N-1].err;
        res_next.out_day     = DAY_W'(e8_reg - E_W'(month_ofs(m8_reg)) + E_W'(1));
        res_next.out_month   = wrap ? m8_reg - 4'd9 : m8_reg + 4'd3;
        res_next.out_year    = YEAR_W'(YS_W'(yb8_reg) + YS_W'(wrap) - YS_W'(SER_BIAS_Y));
        if (side_reg[SIDE_N-1].blank)
        begin
            res_next.out_day   = '0;
            res_next.out_month = '0;
            res_next.out_year  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DATE_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < SIDE_N; i++)
            side_reg[i] <= side_reg[i-1];
        a1_reg  <= a1_next;
        pb2_reg <= pb2_next;
        a2_reg  <= a1_reg;
        b3_reg  <= b3_next;
        a3_reg  <= a2_reg;
        c4_reg  <= c4_next;
        b4_reg  <= b3_reg;
        py5_reg <= py5_next;
        c5_reg  <= c4_reg;
        b5_reg  <= b4_reg;
        y6_reg  <= y6_next;
        c6_reg  <= c5_reg;
        b6_reg  <= b5_reg;
        e7_reg  <= e7_next;
        yb7_reg <= yb7_next;
        m8_reg  <= m8_next;
        e8_reg  <= e7_reg;
        yb8_reg <= yb7_reg;
        res_reg <= res_next;
    end

    assign out_valid = vld_reg[DATE_STAGES-1];
    assign result    = res_reg;

endmodule

### rtl/core/gregorian_day_number_unit_top.sv
// top level of the gregorian day-number unit: two date-to-serial pipes,
// an action stage and the serial-to-date pipe; depends on gdn_pkg
//
// A request is taken on every clock edge where start is high and busy is
// low. busy never rises: the datapath is a fixed pipeline with no feedback,
// so a new request may follow in every cycle.
// Each request gives exactly one result: done is high for one cycle and
// result holds the fields during that cycle only.
// Results leave in request order.
// Stages: three for the two date-to-serial pipes (multiply by reciprocal
// for the century terms), one for the action (sum, difference, offset),
// nine for serial to date (two reciprocal divides, each corrected in the
// following stage, then the month search and the calendar fields).
// The receiver has no way to hold results; none is needed.
// Reset clears only the valid bits; requests in flight are dropped.
// Dates are not checked; a serial or sum outside years 0 to YEAR_MAX sets
// range_error and gives a zero date.
module gregorian_day_number_unit_top
    import gdn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  gdn_req_t req,
    output logic     done,
    output gdn_res_t result
);

    logic [SER_STAGES-1:0]   vld_reg;
    action_t                 act_reg [SER_STAGES];
    logic signed [NUM_W-1:0] amt_reg [SER_STAGES];

    logic [SER_W-1:0]        ser1;
    logic [SER_W-1:0]        ser2;

    logic signed [SUM_W-1:0] s_next, s_reg;
    gdn_tag_t                tag_next, tag_reg;
    logic                    vld4_reg;

    assign busy = 1'b0;

    gdn_serial u_first (
        .clk    (clk),
        .year   (req.first_year),
        .month  (req.first_month),
        .day    (req.first_day),
        .serial (ser1)
    );

    gdn_serial u_second (
        .clk    (clk),
        .year   (req.second_year),
        .month  (req.second_month),
        .day    (req.second_day),
        .serial (ser2)
    );

    // action stage
    always_comb
    begin
        tag_next.conv = (act_reg[SER_STAGES-1] == ACT_SERIAL_TO_DATE)
                     || (act_reg[SER_STAGES-1] == ACT_ADD_DAYS);
        case (act_reg[SER_STAGES-1])
            ACT_DATE_TO_SERIAL: tag_next.number = NUM_W'(ser1);
            ACT_DAYS_BETWEEN:   tag_next.number = NUM_W'(ser2) - NUM_W'(ser1);
            default:            tag_next.number = '0;
        endcase
        if (act_reg[SER_STAGES-1] == ACT_ADD_DAYS)
            s_next = $signed(SUM_W'(ser1) + SUM_W'(amt_reg[SER_STAGES-1]));
        else
            s_next = SUM_W'(amt_reg[SER_STAGES-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[SER_STAGES-2:0], start && !busy};
            vld4_reg <= vld_reg[SER_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg[0] <= req.action;
        amt_reg[0] <= req.amount;
        for (int i = 1; i < SER_STAGES; i++)
        begin
            act_reg[i] <= act_reg[i-1];
            amt_reg[i] <= amt_reg[i-1];
        end
        s_reg   <= s_next;
        tag_reg <= tag_next;
    end

    gdn_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld4_reg),
        .serial    (s_reg),
        .tag       (tag_reg),
        .out_valid (done),
        .result    (result)
    );

    // every request is answered by exactly one result on done
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not produce a result on time");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // only the conversions to a date can fall outside the supported years
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.range_error) |->
            ($past(req.action, LATENCY) == ACT_SERIAL_TO_DATE
             || $past(req.action, LATENCY) == ACT_ADD_DAYS))
        else $error("range error on a date-to-serial action");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.range_error) |->
            (result.out_month == '0 && result.out_day == '0 && result.number == '0))
        else $error("range error with a nonzero date");

endmodule
